// ----- rtl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// Process table scheduler package
// Shared types, codes and default sizes for the process table scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TasksDef      = 3;
  localparam int QueueDepthDef = 8;

  localparam logic [11:0] PRIO_RESET = 12'd585;

  localparam logic [7:0] MSG_START   = 8'd1;
  localparam logic [7:0] MSG_NEW_PC  = 8'd2;
  localparam logic [7:0] MSG_NEW_ACC = 8'd3;

  localparam int MsgW = 40;

  typedef enum logic [2:0] {
    CMD_RR   = 3'd0,
    CMD_PRIO = 3'd1,
    CMD_SEND = 3'd2,
    CMD_RECV = 3'd3,
    CMD_TERM = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_SWITCHED = 3'd1,
    STAT_NO_READY = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4,
    STAT_BAD_MSG  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_TERM    = 2'd3
  } task_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SWITCH,
    ST_POP,
    ST_EMIT
  } fsm_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [1:0]         target_task;
    logic [7:0]         message_code;
    logic signed [31:0] message_data;
    logic [15:0]        running_pc;
    logic signed [31:0] running_acc;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         current_task;
    logic [15:0]        restored_pc;
    logic signed [31:0] restored_acc;
    logic [7:0]         received_code;
    logic               all_terminated;
  } out_t;

  typedef struct packed {
    logic       start;
    logic       prio_mode;
    logic [1:0] cur;
  } pick_ctrl_t;

  typedef struct packed {
    logic       last;
    logic       found;
    logic [1:0] best;
  } pick_stat_t;

endpackage

// ----- rtl/process_table_scheduler.sv -----
// ----------------------------------------------------------------------------
// Process table scheduler
// Task table with per-task message queues, round-robin and priority switching.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i   (pts_pkg::in_t)
// out       output     out_valid_o / out_ready_i out_data_o  (pts_pkg::out_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (task priorities)
//
// A schedule command passes through the decode, scan, switch and emit states to the result beat;
// in the scan state the picker examines one task per cycle.
// A receive that pops a message also passes through the pop state for the registered queue memory read.
// Send, terminate, a receive from an empty queue and other commands go from decode straight to emit.
// Reset clears the table at once; no item is accepted while a command is in work.
// A stalled result beat holds the block until it is taken.
// ----------------------------------------------------------------------------
module process_table_scheduler #(
  parameter int TASKS       = pts_pkg::TasksDef,
  parameter int QUEUE_DEPTH = pts_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pts_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pts_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [11:0]    cfg_wdata_i
);

  localparam int TW  = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int SW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW1 = SW + 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AW  = TW + SW;

  pts_pkg::fsm_e                      state_q, state_d;
  pts_pkg::in_t                       in_q;
  pts_pkg::out_t                      res_q;
  pts_pkg::out_t                      out_q;
  logic                               out_valid_q;
  logic [11:0]                        prio_q;
  logic [TW-1:0]                      cur_q;
  pts_pkg::task_state_e [TASKS-1:0]   task_q;
  logic [15:0]                        pc_q   [TASKS];
  logic signed [31:0]                 acc_q  [TASKS];
  logic [FW-1:0]                      fill_q [TASKS];
  logic [SW-1:0]                      head_q [TASKS];

  pts_pkg::pick_ctrl_t pick_ctrl;
  pts_pkg::pick_stat_t pick_stat;

  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [pts_pkg::MsgW-1:0] ram_rdata;
  logic                 emit;

  logic [TW-1:0]        tgt;
  logic                 tgt_ok;
  logic [SW1-1:0]       wsum;
  logic [SW-1:0]        wr_slot;
  logic [SW1-1:0]       hsum;
  logic [SW-1:0]        head_next;
  logic [TW-1:0]        best;
  logic [7:0]           pop_code;
  logic                 all_term;
  logic                 fill_ok;
  pts_pkg::out_t        dec_res;

  always_comb begin
    tgt     = in_q.target_task[TW-1:0];
    tgt_ok  = 32'(in_q.target_task) < TASKS;
    wsum    = SW1'(head_q[tgt]) + SW1'(fill_q[tgt]);
    if (wsum >= SW1'(QUEUE_DEPTH)) begin
      wsum = wsum - SW1'(QUEUE_DEPTH);
    end
    wr_slot = wsum[SW-1:0];
    hsum    = SW1'(head_q[tgt]) + 1'b1;
    head_next = (hsum == SW1'(QUEUE_DEPTH)) ? '0 : hsum[SW-1:0];
    best    = pick_stat.best[TW-1:0];
    pop_code = ram_rdata[pts_pkg::MsgW-1 -: 8];
    all_term = 1'b1;
    fill_ok  = 1'b1;
    for (int t = 0; t < TASKS; t++) begin
      if (task_q[t] != pts_pkg::TS_TERM) begin
        all_term = 1'b0;
      end
      if (fill_q[t] > FW'(QUEUE_DEPTH)) begin
        fill_ok = 1'b0;
      end
    end
    dec_res = '0;
    case (in_q.cmd)
      pts_pkg::CMD_SEND: begin
        if (tgt_ok && (fill_q[tgt] >= FW'(QUEUE_DEPTH))) begin
          dec_res.status = pts_pkg::STAT_FULL;
        end
      end
      pts_pkg::CMD_RECV: begin
        if (tgt_ok && (fill_q[tgt] == '0)) begin
          dec_res.status = pts_pkg::STAT_EMPTY;
        end
      end
      default: begin
        dec_res.status = pts_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    state_d             = state_q;
    in_ready_o          = (state_q == pts_pkg::ST_IDLE);
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    ram_waddr           = {tgt, wr_slot};
    ram_raddr           = {tgt, head_q[tgt]};
    pick_ctrl.start     = 1'b0;
    pick_ctrl.prio_mode = (in_q.cmd == pts_pkg::CMD_PRIO);
    pick_ctrl.cur       = 2'(cur_q);
    emit                = 1'b0;
    case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pts_pkg::ST_DECODE;
        end
      end
      pts_pkg::ST_DECODE: begin
        state_d = pts_pkg::ST_EMIT;
        case (in_q.cmd)
          pts_pkg::CMD_RR, pts_pkg::CMD_PRIO: begin
            pick_ctrl.start = 1'b1;
            state_d         = pts_pkg::ST_SCAN;
          end
          pts_pkg::CMD_SEND: begin
            ram_we = tgt_ok && (fill_q[tgt] < FW'(QUEUE_DEPTH));
          end
          pts_pkg::CMD_RECV: begin
            if (tgt_ok && (fill_q[tgt] != '0)) begin
              ram_re  = 1'b1;
              state_d = pts_pkg::ST_POP;
            end
          end
          default: begin
            state_d = pts_pkg::ST_EMIT;
          end
        endcase
      end
      pts_pkg::ST_SCAN: begin
        if (pick_stat.last) begin
          state_d = pts_pkg::ST_SWITCH;
        end
      end
      pts_pkg::ST_SWITCH, pts_pkg::ST_POP: begin
        state_d = pts_pkg::ST_EMIT;
      end
      pts_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = pts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= pts_pkg::PRIO_RESET;
    end else if (cfg_we_i) begin
      prio_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      res_q <= '0;
      for (int t = 0; t < TASKS; t++) begin
        task_q[t] <= pts_pkg::TS_READY;
        pc_q[t]   <= '0;
        acc_q[t]  <= '0;
        fill_q[t] <= '0;
        head_q[t] <= '0;
      end
    end else begin
      case (state_q)
        pts_pkg::ST_DECODE: begin
          res_q <= dec_res;
          case (in_q.cmd)
            pts_pkg::CMD_SEND: begin
              if (tgt_ok && (fill_q[tgt] < FW'(QUEUE_DEPTH))) begin
                fill_q[tgt] <= fill_q[tgt] + 1'b1;
              end
            end
            pts_pkg::CMD_TERM: begin
              if (tgt_ok) begin
                task_q[tgt] <= pts_pkg::TS_TERM;
              end
            end
            default: begin
            end
          endcase
        end
        pts_pkg::ST_SWITCH: begin
          if (pick_stat.found) begin
            pc_q[cur_q]  <= in_q.running_pc;
            acc_q[cur_q] <= in_q.running_acc;
            if ((best != cur_q) && (task_q[cur_q] != pts_pkg::TS_TERM)) begin
              task_q[cur_q] <= pts_pkg::TS_READY;
            end
            task_q[best] <= pts_pkg::TS_RUNNING;
            cur_q        <= best;
            res_q.status <= pts_pkg::STAT_SWITCHED;
            res_q.restored_pc  <= (best == cur_q) ? in_q.running_pc : pc_q[best];
            res_q.restored_acc <= (best == cur_q) ? in_q.running_acc : acc_q[best];
          end else begin
            res_q.status <= pts_pkg::STAT_NO_READY;
          end
        end
        pts_pkg::ST_POP: begin
          head_q[tgt] <= head_next;
          fill_q[tgt] <= fill_q[tgt] - 1'b1;
          res_q.received_code <= pop_code;
          case (pop_code)
            pts_pkg::MSG_START:   task_q[tgt] <= pts_pkg::TS_RUNNING;
            pts_pkg::MSG_NEW_PC:  pc_q[tgt]   <= ram_rdata[15:0];
            pts_pkg::MSG_NEW_ACC: acc_q[tgt]  <= ram_rdata[31:0];
            default:              res_q.status <= pts_pkg::STAT_BAD_MSG;
          endcase
        end
        default: begin
          res_q <= res_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= '{status:         res_q.status,
                 current_task:   2'(cur_q),
                 restored_pc:    res_q.restored_pc,
                 restored_acc:   res_q.restored_acc,
                 received_code:  res_q.received_code,
                 all_terminated: all_term};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  pts_pick #(
    .TASKS(TASKS)
  ) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prio_i       (prio_q),
    .task_state_i (task_q),
    .ctrl_i       (pick_ctrl),
    .stat_o       (pick_stat)
  );

  pts_ram #(
    .WIDTH(pts_pkg::MsgW),
    .DEPTH(2 ** AW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_q.message_code, in_q.message_data}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_accept_decode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == pts_pkg::ST_DECODE)
    else $error("Accepted beat did not start decoding.");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_ok)
    else $error("Queue fill count exceeds the queue depth.");

  a_emit_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == pts_pkg::ST_EMIT)
    else $error("Result beat raised outside the emit state.");

  a_switch_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pts_pkg::ST_SWITCH && pick_stat.found |=> task_q[cur_q] == pts_pkg::TS_RUNNING)
    else $error("Switched-to task is not running.");

  a_current_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < TASKS)
    else $error("Current task index out of range.");

endmodule

// ----- rtl/pts_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/pts_pick.sv -----
// ----------------------------------------------------------------------------
// Task picker
// Examines one task per cycle to find the next round-robin or best priority task.
// ----------------------------------------------------------------------------
module pts_pick #(
  parameter int TASKS = pts_pkg::TasksDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [11:0]                            prio_i,
  input  pts_pkg::task_state_e [TASKS-1:0]       task_state_i,
  input  pts_pkg::pick_ctrl_t                    ctrl_i,
  output pts_pkg::pick_stat_t                    stat_o
);

  localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [TW-1:0] LAST = TW'(TASKS - 1);

  logic          busy_q;
  logic          mode_q;
  logic [TW-1:0] cnt_q;
  logic [TW-1:0] pos_q;
  logic          found_q;
  logic [TW-1:0] best_q;
  logic [2:0]    bestp_q;

  logic [2:0]    prios [TASKS];
  logic [2:0]    pos_prio;
  logic          hit;
  logic [TW-1:0] cur;
  logic [TW-1:0] pos_next;

  always_comb begin
    for (int t = 0; t < TASKS; t++) begin
      prios[t] = prio_i[3*t +: 3];
    end
    pos_prio = prios[pos_q];
    if (mode_q) begin
      hit = (task_state_i[pos_q] == pts_pkg::TS_READY) && (!found_q || pos_prio > bestp_q);
    end else begin
      hit = !found_q && (task_state_i[pos_q] != pts_pkg::TS_TERM);
    end
    cur      = ctrl_i.cur[TW-1:0];
    pos_next = (pos_q == LAST) ? '0 : pos_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      mode_q  <= 1'b0;
      cnt_q   <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
      best_q  <= '0;
      bestp_q <= '0;
    end else if (ctrl_i.start) begin
      busy_q  <= 1'b1;
      mode_q  <= ctrl_i.prio_mode;
      cnt_q   <= '0;
      found_q <= 1'b0;
      if (ctrl_i.prio_mode) begin
        pos_q <= '0;
      end else begin
        pos_q <= (cur == LAST) ? '0 : cur + 1'b1;
      end
    end else if (busy_q) begin
      if (hit) begin
        found_q <= 1'b1;
        best_q  <= pos_q;
        bestp_q <= pos_prio;
      end
      pos_q <= pos_next;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign stat_o.last  = busy_q && (cnt_q == LAST);
  assign stat_o.found = found_q;
  assign stat_o.best  = 2'(best_q);

endmodule
